/* sv/lobm_pkg.sv */
package lobm_pkg;

   localparam logic [1:0] ST_LIMIT_OK  = 2'd0;
   localparam logic [1:0] ST_LIMIT_REJ = 2'd1;
   localparam logic [1:0] ST_FILL      = 2'd2;
   localparam logic [1:0] ST_MKT_DONE  = 2'd3;

   localparam int QTY_W  = 31;
   localparam int TICK_W = 8;
   localparam int FILL_W = 6;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_L_META = 7'b0000100,
      S_M_META = 7'b0001000,
      S_M_QTY  = 7'b0010000,
      S_DONE   = 7'b0100000,
      S_M_INIT = 7'b1000000
   } state_type;

endpackage

/* sv/limit_order_book_matcher_unit.sv */
// Limit item: accept, head/count read and update, reply; a tick beyond the book is
// rejected without the read. Market item: accept, setup, a head/count read per price
// level visited, a queue step per fill (up to MAX_FILLS), and the closing status.
// One item in work at a time; the next item is taken while the last result waits.
// Reset: synchronous; a clearing pass zeroes every head/count entry (512 by default),
// and no item is accepted until it ends.
module limit_order_book_matcher_unit
   import lobm_pkg::*;
#(
   parameter int PRICE_LEVELS = 256,
   parameter int QUEUE_DEPTH  = 16,
   parameter int MAX_FILLS    = 63
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic              req_side,
   input  logic [TICK_W-1:0] req_price_tick,
   input  logic [QTY_W-1:0]  req_quantity,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [TICK_W-1:0] rsp_fill_tick,
   output logic [QTY_W-1:0]  rsp_fill_quantity,
   output logic [QTY_W-1:0]  rsp_remaining_quantity,
   output logic              rsp_last
);

   localparam int LW  = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
   localparam int SW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int AW  = LW + 1;
   localparam int QAW = AW + SW;
   localparam int MW  = SW + CW;

   logic [MW-1:0]    meta_mem [2**AW];
   logic [QTY_W-1:0] q_mem [2**QAW];

   state_type        state_ff, state_in;
   logic             side_ff, side_in;
   logic [QTY_W-1:0] qty_ff, qty_in;
   logic [LW-1:0]    level_ff, level_in;
   logic [SW-1:0]    head_ff, head_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [FILL_W-1:0] n_ff, n_in;
   logic [1:0]       status_ff, status_in;
   logic [AW-1:0]    clr_ff, clr_in;

   logic [MW-1:0]    meta_rd_ff;
   logic [QTY_W-1:0] q_rd_ff;

   logic             meta_re, meta_we, q_re, q_we;
   logic [AW-1:0]    meta_raddr, meta_waddr;
   logic [MW-1:0]    meta_wdata;
   logic [QAW-1:0]   q_raddr, q_waddr;
   logic [QTY_W-1:0] q_wdata;

   logic             rsp_valid_ff, rsp_last_ff;
   logic [1:0]       rsp_status_ff;
   logic [TICK_W-1:0] rsp_tick_ff;
   logic [QTY_W-1:0] rsp_fq_ff, rsp_rq_ff;
   logic             emit;
   logic [1:0]       e_status;
   logic [TICK_W-1:0] e_tick;
   logic [QTY_W-1:0] e_fq, e_rq;
   logic             e_last;

   logic             out_free;
   logic [SW-1:0]    rd_head;
   logic [CW-1:0]    rd_cnt;
   logic [SW+1:0]    slot_sum;
   logic [SW-1:0]    slot;
   logic [SW-1:0]    head_nx;
   logic [CW-1:0]    cnt_nx;
   logic             last_level;
   logic [LW-1:0]    level_nx;
   logic [LW-1:0]    req_level;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rd_head    = meta_rd_ff[MW-1:CW];
   assign rd_cnt     = meta_rd_ff[CW-1:0];
   assign slot_sum   = (SW+2)'(rd_head) + (SW+2)'(rd_cnt);
   assign slot       = (slot_sum >= (SW+2)'(QUEUE_DEPTH)) ?
                       SW'(slot_sum - (SW+2)'(QUEUE_DEPTH)) : SW'(slot_sum);
   assign head_nx    = (head_ff == SW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + SW'(1);
   assign cnt_nx     = cnt_ff - CW'(1);
   assign last_level = side_ff ? (level_ff == LW'(PRICE_LEVELS - 1)) : (level_ff == '0);
   assign level_nx   = side_ff ? level_ff + LW'(1) : level_ff - LW'(1);
   assign req_level  = LW'(req_price_tick);
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      side_in    = side_ff;
      qty_in     = qty_ff;
      level_in   = level_ff;
      head_in    = head_ff;
      cnt_in     = cnt_ff;
      n_in       = n_ff;
      status_in  = status_ff;
      clr_in     = clr_ff;
      meta_re    = 1'b0;
      meta_raddr = {side_ff, level_ff};
      meta_we    = 1'b0;
      meta_waddr = {side_ff, level_ff};
      meta_wdata = {head_ff, cnt_ff};
      q_re       = 1'b0;
      q_raddr    = {side_ff, level_ff, head_ff};
      q_we       = 1'b0;
      q_waddr    = {side_ff, level_ff, slot};
      q_wdata    = qty_ff;
      emit       = 1'b0;
      e_status   = ST_FILL;
      e_tick     = 8'(level_ff);
      e_fq       = '0;
      e_rq       = '0;
      e_last     = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            meta_wdata = '0;
            clr_in     = clr_ff + AW'(1);
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               side_in = req_side;
               qty_in  = req_quantity;
               n_in    = '0;
               if (req_kind) begin
                  state_in  = S_M_INIT;
                  status_in = ST_MKT_DONE;
                  level_in  = req_side ? '0 : LW'(PRICE_LEVELS - 1);
               end else if (32'(req_price_tick) >= 32'(PRICE_LEVELS)) begin
                  state_in  = S_DONE;
                  status_in = ST_LIMIT_REJ;
               end else begin
                  state_in   = S_L_META;
                  level_in   = req_level;
                  meta_re    = 1'b1;
                  meta_raddr = {req_side, req_level};
               end
            end
         end
         S_L_META: begin
            if (32'(rd_cnt) >= 32'(QUEUE_DEPTH)) begin
               status_in = ST_LIMIT_REJ;
            end else begin
               status_in = ST_LIMIT_OK;
               if (qty_ff != '0) begin
                  q_we       = 1'b1;
                  meta_we    = 1'b1;
                  meta_wdata = {rd_head, rd_cnt + CW'(1)};
               end
            end
            state_in = S_DONE;
         end
         S_M_INIT: begin
            if (qty_ff == '0) begin
               state_in = S_DONE;
            end else begin
               meta_re  = 1'b1;
               state_in = S_M_META;
            end
         end
         S_M_META: begin
            head_in = rd_head;
            cnt_in  = rd_cnt;
            if (rd_cnt != '0) begin
               q_re     = 1'b1;
               q_raddr  = {side_ff, level_ff, rd_head};
               state_in = S_M_QTY;
            end else if (last_level) begin
               state_in = S_DONE;
            end else begin
               level_in   = level_nx;
               meta_re    = 1'b1;
               meta_raddr = {side_ff, level_nx};
            end
         end
         S_M_QTY: begin
            if (out_free) begin
               emit = 1'b1;
               n_in = n_ff + FILL_W'(1);
               if (qty_ff < q_rd_ff) begin
                  e_fq     = qty_ff;
                  q_we     = 1'b1;
                  q_waddr  = {side_ff, level_ff, head_ff};
                  q_wdata  = q_rd_ff - qty_ff;
                  qty_in   = '0;
                  state_in = S_DONE;
               end else begin
                  e_fq       = q_rd_ff;
                  qty_in     = qty_ff - q_rd_ff;
                  head_in    = head_nx;
                  cnt_in     = cnt_nx;
                  meta_we    = 1'b1;
                  meta_wdata = {head_nx, cnt_nx};
                  if (qty_ff == q_rd_ff ||
                      (7'(n_ff) + 7'd1) >= 7'(MAX_FILLS)) begin
                     state_in = S_DONE;
                  end else if (cnt_nx != '0) begin
                     q_re    = 1'b1;
                     q_raddr = {side_ff, level_ff, head_nx};
                  end else if (last_level) begin
                     state_in = S_DONE;
                  end else begin
                     level_in   = level_nx;
                     meta_re    = 1'b1;
                     meta_raddr = {side_ff, level_nx};
                     state_in   = S_M_META;
                  end
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               e_status = status_ff;
               e_tick   = '0;
               e_rq     = (status_ff == ST_MKT_DONE) ? qty_ff : '0;
               e_last   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
      if (meta_re) meta_rd_ff <= meta_mem[meta_raddr];
      if (q_we) q_mem[q_waddr] <= q_wdata;
      if (q_re) q_rd_ff <= q_mem[q_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         n_ff     <= n_in;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      side_ff   <= side_in;
      qty_ff    <= qty_in;
      level_ff  <= level_in;
      head_ff   <= head_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      if (emit) begin
         rsp_status_ff <= e_status;
         rsp_tick_ff   <= e_tick;
         rsp_fq_ff     <= e_fq;
         rsp_rq_ff     <= e_rq;
         rsp_last_ff   <= e_last;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_fill_tick          = rsp_tick_ff;
   assign rsp_fill_quantity      = rsp_fq_ff;
   assign rsp_remaining_quantity = rsp_rq_ff;
   assign rsp_last               = rsp_last_ff;

   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      7'(n_ff) <= 7'(MAX_FILLS))
      else $error("fill count beyond cap");

   a_fill_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FILL |-> !rsp_last)
      else $error("fill marked last");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwritten");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("accepted item not started");

endmodule

/* dv/lobm_tb_pkg.sv */
package lobm_tb_pkg;

   localparam logic KIND_LIMIT  = 1'b0;
   localparam logic KIND_MARKET = 1'b1;
   localparam logic SIDE_BID    = 1'b0;
   localparam logic SIDE_ASK    = 1'b1;

   localparam int BOOK_LEVELS = 256;
   localparam int LEVEL_DEPTH = 16;
   localparam int FILL_CAP    = 63;

endpackage

/* dv/lobm_checker.sv */
module lobm_checker
   import lobm_pkg::*;
   import lobm_tb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_kind,
   input  logic              req_side,
   input  logic [TICK_W-1:0] req_price_tick,
   input  logic [QTY_W-1:0]  req_quantity,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [1:0]        rsp_status,
   input  logic [TICK_W-1:0] rsp_fill_tick,
   input  logic [QTY_W-1:0]  rsp_fill_quantity,
   input  logic [QTY_W-1:0]  rsp_remaining_quantity,
   input  logic              rsp_last,
   output int                errors,
   output int                outstanding,
   output int                fills_seen,
   output int                rejects_seen,
   output int                capped_walks
);

   typedef struct packed {
      logic [1:0]        status;
      logic [TICK_W-1:0] tick;
      logic [QTY_W-1:0]  fill_qty;
      logic [QTY_W-1:0]  left_qty;
      logic              last;
   } trade_result_type;

   trade_result_type pending_results[$];

   logic [QTY_W-1:0] ask_book [BOOK_LEVELS*LEVEL_DEPTH];
   logic [QTY_W-1:0] bid_book [BOOK_LEVELS*LEVEL_DEPTH];
   logic [3:0]       ask_front [BOOK_LEVELS];
   logic [3:0]       bid_front [BOOK_LEVELS];
   logic [4:0]       ask_depth [BOOK_LEVELS];
   logic [4:0]       bid_depth [BOOK_LEVELS];

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
   endtask

   function automatic void push_result(logic [1:0] st, int tk, logic [QTY_W-1:0] fq,
                                       logic [QTY_W-1:0] lq, logic lst);
      trade_result_type r;
      r.status = st;
      r.tick = tk[TICK_W-1:0];
      r.fill_qty = fq;
      r.left_qty = lq;
      r.last = lst;
      pending_results.push_back(r);
   endfunction

   function automatic void match_order(logic kind, logic side, logic [TICK_W-1:0] tick,
                                       logic [QTY_W-1:0] qty);
      int lvl;
      int idx;
      int nfill;
      logic [QTY_W-1:0] front;
      nfill = 0;
      if (kind == KIND_LIMIT) begin
         if (side == SIDE_ASK ? ask_depth[tick] >= LEVEL_DEPTH
                              : bid_depth[tick] >= LEVEL_DEPTH) begin
            push_result(ST_LIMIT_REJ, 0, '0, '0, 1'b1);
            rejects_seen++;
            return;
         end
         if (qty != 0) begin
            if (side == SIDE_ASK) begin
               ask_book[tick*LEVEL_DEPTH + ((ask_front[tick] + ask_depth[tick]) % LEVEL_DEPTH)]
                  = qty;
               ask_depth[tick]++;
            end else begin
               bid_book[tick*LEVEL_DEPTH + ((bid_front[tick] + bid_depth[tick]) % LEVEL_DEPTH)]
                  = qty;
               bid_depth[tick]++;
            end
         end
         push_result(ST_LIMIT_OK, 0, '0, '0, 1'b1);
         return;
      end
      for (int step = 0; step < BOOK_LEVELS; step++) begin
         lvl = (side == SIDE_ASK) ? step : BOOK_LEVELS - 1 - step;
         if (qty == 0 || nfill >= FILL_CAP) break;
         while ((side == SIDE_ASK ? ask_depth[lvl] : bid_depth[lvl]) != 0 && qty != 0
                && nfill < FILL_CAP) begin
            idx = lvl*LEVEL_DEPTH + (side == SIDE_ASK ? ask_front[lvl] : bid_front[lvl]);
            front = (side == SIDE_ASK) ? ask_book[idx] : bid_book[idx];
            nfill++;
            if (qty < front) begin
               if (side == SIDE_ASK) ask_book[idx] = front - qty;
               else bid_book[idx] = front - qty;
               push_result(ST_FILL, lvl, qty, '0, 1'b0);
               qty = '0;
            end else begin
               push_result(ST_FILL, lvl, front, '0, 1'b0);
               qty = qty - front;
               if (side == SIDE_ASK) begin
                  ask_front[lvl]++;
                  ask_depth[lvl]--;
               end else begin
                  bid_front[lvl]++;
                  bid_depth[lvl]--;
               end
            end
         end
      end
      if (nfill >= FILL_CAP) capped_walks++;
      push_result(ST_MKT_DONE, 0, '0, qty, 1'b1);
   endfunction

   always @(posedge clock) begin
      trade_result_type want;
      if (reset) begin
         pending_results.delete();
         errors = 0;
         fills_seen = 0;
         rejects_seen = 0;
         capped_walks = 0;
         for (int i = 0; i < BOOK_LEVELS; i++) begin
            ask_front[i] = '0;
            bid_front[i] = '0;
            ask_depth[i] = '0;
            bid_depth[i] = '0;
         end
      end else begin
         if (req_valid && req_ready)
            match_order(req_kind, req_side, req_price_tick, req_quantity);
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               want = pending_results.pop_front();
               if (rsp_status == ST_FILL) fills_seen++;
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d want %0d", rsp_status, want.status));
               if (rsp_fill_tick !== want.tick)
                  report_mismatch($sformatf("fill_tick %0d want %0d", rsp_fill_tick,
                                            want.tick));
               if (rsp_fill_quantity !== want.fill_qty)
                  report_mismatch($sformatf("fill_quantity %0d want %0d",
                                            rsp_fill_quantity, want.fill_qty));
               if (rsp_remaining_quantity !== want.left_qty)
                  report_mismatch($sformatf("remaining_quantity %0d want %0d",
                                            rsp_remaining_quantity, want.left_qty));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b want %0b", rsp_last, want.last));
            end
         end
      end
      outstanding = pending_results.size();
   end

endmodule

/* dv/tb_limit_order_book_matcher_unit.sv */
module tb_limit_order_book_matcher_unit;
   import lobm_pkg::*;
   import lobm_tb_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 1200;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_kind;
   logic              req_side;
   logic [TICK_W-1:0] req_price_tick;
   logic [QTY_W-1:0]  req_quantity;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_status;
   logic [TICK_W-1:0] rsp_fill_tick;
   logic [QTY_W-1:0]  rsp_fill_quantity;
   logic [QTY_W-1:0]  rsp_remaining_quantity;
   logic              rsp_last;

   int errors;
   int outstanding;
   int fills_seen;
   int rejects_seen;
   int capped_walks;
   int cycle_count = 0;
   int orders_sent;
   int burst_left;
   int stall_mode;

   limit_order_book_matcher_unit DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_kind               (req_kind),
      .req_side               (req_side),
      .req_price_tick         (req_price_tick),
      .req_quantity           (req_quantity),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_fill_tick          (rsp_fill_tick),
      .rsp_fill_quantity      (rsp_fill_quantity),
      .rsp_remaining_quantity (rsp_remaining_quantity),
      .rsp_last               (rsp_last)
   );

   lobm_checker book_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_kind               (req_kind),
      .req_side               (req_side),
      .req_price_tick         (req_price_tick),
      .req_quantity           (req_quantity),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_fill_tick          (rsp_fill_tick),
      .rsp_fill_quantity      (rsp_fill_quantity),
      .rsp_remaining_quantity (rsp_remaining_quantity),
      .rsp_last               (rsp_last),
      .errors                 (errors),
      .outstanding            (outstanding),
      .fills_seen             (fills_seen),
      .rejects_seen           (rejects_seen),
      .capped_walks           (capped_walks)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_limit_order_book_matcher_unit: errors");
         $finish;
      end
   end

   // receiver: stall pattern changes every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   task automatic send_order(input logic kind, input logic side, input int tick,
                             input logic [QTY_W-1:0] qty);
      int gap;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_side <= side;
      req_price_tick <= tick[TICK_W-1:0];
      req_quantity <= qty;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      orders_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [QTY_W-1:0] pick_quantity();
      case ($urandom_range(0, 9))
         0: return QTY_W'($urandom());
         1: return {QTY_W{1'b1}};
         2: return '0;
         default: return QTY_W'($urandom_range(1, 100));
      endcase
   endfunction

   initial begin
      int base;
      int nload;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_LIMIT;
      req_side = SIDE_BID;
      req_price_tick = '0;
      req_quantity = '0;
      orders_sent = 0;
      burst_left = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed
      send_order(KIND_MARKET, SIDE_BID, 0, 31'd40);
      send_order(KIND_MARKET, SIDE_ASK, 0, 31'd0);
      send_order(KIND_LIMIT, SIDE_BID, 7, 31'd0);
      send_order(KIND_LIMIT, SIDE_BID, 0, {QTY_W{1'b1}});
      send_order(KIND_LIMIT, SIDE_BID, 255, 31'd5);
      send_order(KIND_MARKET, SIDE_BID, 0, 31'd5);
      send_order(KIND_MARKET, SIDE_BID, 0, 31'd3);
      for (int i = 0; i < LEVEL_DEPTH + 1; i++)
         send_order(KIND_LIMIT, SIDE_ASK, 255, 31'($urandom_range(1, 1000)));
      send_order(KIND_MARKET, SIDE_ASK, 0, {QTY_W{1'b1}});
      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);

      // random episodes: load the book, then sweep it
      while (orders_sent < 360) begin
         base = $urandom_range(0, BOOK_LEVELS - 16);
         nload = $urandom_range(4, 40);
         for (int i = 0; i < nload; i++) begin
            if ($urandom_range(0, 1) == 0)
               send_order(KIND_LIMIT, 1'($urandom()), base + $urandom_range(0, 7),
                          pick_quantity());
            else
               send_order(KIND_LIMIT, 1'($urandom()), $urandom_range(0, BOOK_LEVELS - 1),
                          pick_quantity());
         end
         for (int i = $urandom_range(1, 3); i > 0; i--)
            send_order(KIND_MARKET, 1'($urandom()), $urandom_range(0, BOOK_LEVELS - 1),
                       ($urandom_range(0, 2) == 0) ? {QTY_W{1'b1}} : pick_quantity());
         if ($urandom_range(0, 5) == 0) begin
            wait_quiet();
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
      end

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d orders: %0d fills, %0d level-full rejects, %0d capped sweeps",
               orders_sent, fills_seen, rejects_seen, capped_walks);
      if (errors == 0) begin
         $display("tb_limit_order_book_matcher_unit: clean");
      end else begin
         $display("tb_limit_order_book_matcher_unit: errors");
      end
      $finish;
   end

endmodule
